// ----- hdl/vtli_pkg.sv -----
// vtli_pkg: shared constants for the vector table linear interpolator.
// No dependencies.
package vtli_pkg;
    localparam int MAX_POINTS_DEF   = 256;
    localparam int MAX_ELEMENTS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;

    localparam logic [1:0] FUNC_WR_POINT = 2'd0;
    localparam logic [1:0] FUNC_WR_VALUE = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [1:0] REG_ELEMENT_COUNT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE     = 2'd2;
endpackage

// ----- hdl/vector_table_linear_interpolator.sv -----
// Vector table linear interpolator: top level with sequencer, divider and multiplier.
// Depends on vtli_pkg and vtli_ram.
//
// Usage: one request channel (i_valid/o_ready) carries writes and queries; one
// result channel (o_valid/i_ready) carries result items. Configuration is a
// plain write port (i_cfg_we, i_cfg_addr, i_cfg_data), to be written by the
// user only while idle; the block itself does not enforce this. Writes (func
// 0/1) give no result; func 3 is dropped. A query reads both ends of the table;
// inside the table it runs a lower-bound binary search of up to
// log2(point_count)+1 steps (address out, compare on the registered read data)
// plus a closing step, reads the bracketing breakpoints, then a restoring divide
// for lambda, then per element two value reads, a subtract, a multiply and an
// add, each result waiting for the receiver. An end vector reads one value per
// element; an out-of-range query gives a single error result. o_ready returns
// in the cycle after the last result of a request is taken.
// One request is worked on at a time; o_ready is high only when the sequencer
// is idle. Each result sits in the output register until taken; a stalled
// receiver holds the sequencer in its wait state, nothing is lost.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// output valid and loads the registers with point_count 1, element_count 1,
// tolerance 1. Table contents are undefined until written: no clearing pass.
module vector_table_linear_interpolator
    import vtli_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_point_index,
    input  logic [2:0]         i_element_index,
    input  logic signed [31:0] i_write_data,
    input  logic signed [31:0] i_query_point,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_out_element,
    output logic [1:0]         o_status,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data
);
    localparam int PW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int VD = MAX_POINTS * MAX_ELEMENTS;
    localparam int VW = $clog2(VD);
    localparam int CW = PW + 1;          // counts up to MAX_POINTS
    localparam int LW = FRAC_BITS + 1;   // lambda up to 2^FRAC_BITS

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LAST, S_RD_FIRST, S_ENDS, S_SRCH_RD, S_SRCH_CMP,
        S_RD_PREV, S_RD_NEXT, S_DIV, S_V_RD, S_V_WAIT, S_V_MUL, S_V_OUT, S_V_SUM,
        S_OUT_WAIT
    } t_state;

    t_state r_state;
    logic [8:0]  r_pcount;
    logic [3:0]  r_ecount;
    logic [15:0] r_tol;

    // effective counts
    logic [CW-1:0] w_n;
    logic [EW:0]   w_m;
    always_comb begin
        if (r_pcount == 9'd0) w_n = CW'(1);
        else if (32'(r_pcount) > MAX_POINTS) w_n = CW'(MAX_POINTS);
        else w_n = CW'(r_pcount);
        if (r_ecount == 4'd0) w_m = (EW+1)'(1);
        else if (32'(r_ecount) > MAX_ELEMENTS) w_m = (EW+1)'(MAX_ELEMENTS);
        else w_m = (EW+1)'(r_ecount);
    end

    // memories
    logic              w_bp_we, w_sv_we;
    logic [PW-1:0]     w_bp_raddr;
    logic [VW-1:0]     w_sv_raddr;
    logic [31:0]       w_bp_rdata, w_sv_rdata;
    logic [PW-1:0]     w_bp_waddr;
    logic [VW-1:0]     w_sv_waddr;

    vtli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_bp_ram (
        .i_clk(i_clk), .i_we(w_bp_we), .i_waddr(w_bp_waddr), .i_wdata(i_write_data),
        .i_raddr(w_bp_raddr), .o_rdata(w_bp_rdata)
    );
    vtli_ram #(.WIDTH(32), .DEPTH(VD)) u_sv_ram (
        .i_clk(i_clk), .i_we(w_sv_we), .i_waddr(w_sv_waddr), .i_wdata(i_write_data),
        .i_raddr(w_sv_raddr), .o_rdata(w_sv_rdata)
    );

    logic w_acc;
    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    logic w_pi_ok, w_ei_ok;
    assign w_pi_ok = (32'(i_point_index) < MAX_POINTS);
    assign w_ei_ok = (32'(i_element_index) < MAX_ELEMENTS);
    assign w_bp_we = w_acc && i_func == FUNC_WR_POINT && w_pi_ok;
    assign w_sv_we = w_acc && i_func == FUNC_WR_VALUE && w_pi_ok && w_ei_ok;
    assign w_bp_waddr = PW'(i_point_index);
    assign w_sv_waddr = VW'(32'(i_point_index) * MAX_ELEMENTS + 32'(i_element_index));

    // query datapath registers
    logic signed [32:0] r_t;
    logic signed [32:0] r_lastp;
    logic [CW-1:0] r_lo, r_cnt, r_k;
    logic [PW-1:0] r_bp_addr;
    logic signed [32:0] r_pp;
    logic [33:0] r_rem;       // divider remainder
    logic [33:0] r_div;       // divisor
    logic [LW-1:0] r_lam;
    logic [5:0]  r_dcnt;
    logic [EW:0] r_e;
    logic [CW-1:0] r_row;     // row for end vector; k otherwise
    logic        r_interp;
    logic signed [31:0] r_vp;
    logic signed [32:0] r_dv;
    logic signed [33+LW:0] r_prod;

    always_comb begin
        logic [CW-1:0] row;
        row = r_row;
        if (r_interp && r_state == S_V_RD) row = r_row - CW'(1);
        w_sv_raddr = VW'(32'(row[PW-1:0]) * MAX_ELEMENTS + 32'(r_e[EW-1:0]));
    end

    logic [CW-1:0] w_step;
    assign w_step = r_cnt >> 1;

    // search probe goes straight to the RAM so the compare sees it next cycle
    assign w_bp_raddr = (r_state == S_SRCH_RD) ? PW'(r_lo + w_step) : r_bp_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pcount <= 9'd1;
            r_ecount <= 4'd1;
            r_tol    <= 16'd1;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_POINT_COUNT:   r_pcount <= i_cfg_data[8:0];
                    REG_ELEMENT_COUNT: r_ecount <= i_cfg_data[3:0];
                    REG_TOLERANCE:     r_tol    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_func == FUNC_QUERY) begin
                        r_t       <= 33'(i_query_point);
                        r_bp_addr <= PW'(w_n - CW'(1));
                        r_state   <= S_RD_LAST;
                    end
                end
                S_RD_LAST: begin
                    r_bp_addr <= '0;
                    r_state   <= S_RD_FIRST;
                end
                S_RD_FIRST: begin
                    r_lastp <= 33'(signed'(w_bp_rdata));
                    r_state <= S_ENDS;
                end
                S_ENDS: begin
                    // w_bp_rdata holds first breakpoint
                    r_e      <= '0;
                    r_interp <= 1'b0;
                    if (r_t >= r_lastp) begin
                        if (r_t > r_lastp + signed'(33'(r_tol))) begin
                            o_value <= '0; o_out_element <= '0;
                            o_status <= ST_ABOVE; o_last <= 1'b1;
                            o_valid <= 1'b1; r_state <= S_OUT_WAIT;
                        end else begin
                            r_row <= w_n - CW'(1); r_state <= S_V_RD;
                        end
                    end else if (r_t <= 33'(signed'(w_bp_rdata))) begin
                        if (r_t < 33'(signed'(w_bp_rdata)) - signed'(33'(r_tol))) begin
                            o_value <= '0; o_out_element <= '0;
                            o_status <= ST_BELOW; o_last <= 1'b1;
                            o_valid <= 1'b1; r_state <= S_OUT_WAIT;
                        end else begin
                            r_row <= '0; r_state <= S_V_RD;
                        end
                    end else begin
                        r_lo <= '0; r_cnt <= w_n;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (r_cnt == '0) begin
                        logic [CW-1:0] k;
                        k = r_lo;
                        if (k > w_n - CW'(1)) k = w_n - CW'(1);
                        if (k < CW'(1)) k = CW'(1);
                        r_k <= k;
                        r_bp_addr <= PW'(k - CW'(1));
                        r_state <= S_RD_PREV;
                    end else begin
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (33'(signed'(w_bp_rdata)) < r_t) begin
                        r_lo  <= r_lo + w_step + CW'(1);
                        r_cnt <= r_cnt - w_step - CW'(1);
                    end else begin
                        r_cnt <= w_step;
                    end
                    r_state <= S_SRCH_RD;
                end
                S_RD_PREV: begin
                    r_bp_addr <= PW'(r_k);
                    r_state   <= S_RD_NEXT;
                end
                S_RD_NEXT: begin
                    r_pp    <= 33'(signed'(w_bp_rdata));
                    r_state <= S_DIV;
                    r_dcnt  <= '0;
                end
                S_DIV: begin
                    if (r_dcnt == '0) begin
                        logic signed [33:0] d, nm;
                        d  = 34'(signed'(w_bp_rdata)) - 34'(r_pp);
                        nm = 34'(r_t) - 34'(r_pp);
                        r_div <= d;
                        r_rem <= nm;
                        r_lam <= '0;
                        if (d <= 0 || nm <= 0) begin
                            r_state <= S_V_RD;
                        end else if (nm >= d) begin
                            r_lam <= LW'(1) << FRAC_BITS;
                            r_state <= S_V_RD;
                        end else begin
                            r_dcnt <= 6'd1;
                        end
                        r_row <= r_k; r_interp <= 1'b1;
                    end else begin
                        // restoring divide: one quotient bit per cycle
                        logic [34:0] sh;
                        sh = {r_rem, 1'b0};
                        if (sh >= 35'(r_div)) begin
                            r_rem <= 34'(sh - 35'(r_div));
                            r_lam <= {r_lam[LW-2:0], 1'b1};
                        end else begin
                            r_rem <= 34'(sh);
                            r_lam <= {r_lam[LW-2:0], 1'b0};
                        end
                        if (r_dcnt == 6'(FRAC_BITS)) r_state <= S_V_RD;
                        else r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                S_V_RD: begin
                    // address issued: prev row (interp) or end row
                    r_state <= S_V_WAIT;
                end
                S_V_WAIT: begin
                    r_vp <= w_sv_rdata;
                    if (r_interp) r_state <= S_V_MUL;
                    else begin
                        o_value <= w_sv_rdata;
                        o_out_element <= 3'(r_e);
                        o_status <= ST_OK;
                        o_last <= (r_e + (EW+1)'(1) == w_m);
                        o_valid <= 1'b1;
                        r_state <= S_OUT_WAIT;
                    end
                end
                S_V_MUL: begin
                    // read data now from next row
                    r_dv <= 33'(signed'(w_sv_rdata)) - 33'(r_vp);
                    r_state <= S_V_OUT;
                end
                S_V_OUT: begin
                    r_prod <= (34+LW)'(r_dv) * signed'((34+LW)'({1'b0, r_lam}));
                    r_state <= S_V_SUM;
                end
                S_V_SUM: begin
                    // arithmetic shift floors the scaled difference
                    o_value <= 32'(34'(r_vp) + 34'(r_prod >>> FRAC_BITS));
                    o_out_element <= 3'(r_e);
                    o_status <= ST_OK;
                    o_last <= (r_e + (EW+1)'(1) == w_m);
                    o_valid <= 1'b1;
                    r_state <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last) r_state <= S_IDLE;
                        else begin
                            r_e <= r_e + (EW+1)'(1);
                            r_state <= S_V_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/vtli_ram.sv -----
// vtli_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module vtli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/vtli_checker.sv -----
// vtli_checker: port-level assertions for the interpolator, bound to the top level.
// Depends on vtli_pkg and vector_table_linear_interpolator.
module vtli_checker
    import vtli_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value,
    input logic [2:0]  o_out_element,
    input logic [1:0]  o_status,
    input logic        o_last
);
    // an error result is a single, final, zero result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_value == 32'd0 && o_out_element == 3'd0)
        else $error("error result malformed");
    // no new request while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during pending result");
    // result holds under stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_last))
        else $error("result changed under stall");
    // taking the final result frees the request side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> o_ready && !o_valid)
        else $error("not idle after final result");
endmodule

bind vector_table_linear_interpolator vtli_checker u_vtli_checker (.*);

// ----- test/tb.sv -----
// tb: self-checking bench for vector_table_linear_interpolator.
// Depends on vtli_pkg and the RTL top level; a scoreboard class predicts the results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vtli_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         element;
        logic [1:0]         status;
        logic               last;
    } interp_result_t;

    // Holds a private copy of the table and registers and predicts each query.
    class interp_scoreboard;
        logic signed [31:0] breakpoint_tbl[256];
        logic signed [31:0] sample_tbl[2048];
        int unsigned        point_count_reg = 1;
        int unsigned        element_count_reg = 1;
        int unsigned        tolerance_reg = 1;
        interp_result_t     pending_results[$];
        int                 mismatches = 0;

        function void write_reg(logic [1:0] addr, logic [15:0] data);
            case (addr)
                REG_POINT_COUNT:   point_count_reg = 32'(data & 16'h1FF);
                REG_ELEMENT_COUNT: element_count_reg = 32'(data & 16'hF);
                REG_TOLERANCE:     tolerance_reg = 32'(data);
                default: ;
            endcase
        endfunction

        function int points_used();
            if (point_count_reg == 0) return 1;
            if (point_count_reg > 256) return 256;
            return point_count_reg;
        endfunction

        function int elements_used();
            if (element_count_reg == 0) return 1;
            if (element_count_reg > 8) return 8;
            return element_count_reg;
        endfunction

        function void queue_expected(interp_result_t r);
            pending_results = {pending_results, r};
        endfunction

        function void push_row(int row, int m);
            interp_result_t r;
            for (int e = 0; e < m; e++) begin
                r.value = sample_tbl[row*8 + e];
                r.element = 3'(e);
                r.status = ST_OK;
                r.last = (e == m - 1);
                queue_expected(r);
            end
        endfunction

        function void push_error(logic [1:0] st);
            interp_result_t r;
            r.value = '0;
            r.element = '0;
            r.status = st;
            r.last = 1'b1;
            queue_expected(r);
        endfunction

        function void predict_query(logic signed [31:0] qp);
            int     n, m, lo, cnt, step, k;
            longint t, p_head, p_tail, tol, pp, pn, diff, num, lambda, vp, vn, prod;
            interp_result_t r;
            n = points_used();
            m = elements_used();
            t = qp;
            p_head = breakpoint_tbl[0];
            p_tail = breakpoint_tbl[n-1];
            tol = tolerance_reg;
            // the upper end is tested first
            if (t >= p_tail) begin
                if (t > p_tail + tol) push_error(ST_ABOVE);
                else push_row(n - 1, m);
                return;
            end
            if (t <= p_head) begin
                if (t < p_head - tol) push_error(ST_BELOW);
                else push_row(0, m);
                return;
            end
            // lower-bound search: first breakpoint not below t
            lo = 0;
            cnt = n;
            while (cnt > 0) begin
                step = cnt / 2;
                if (longint'(breakpoint_tbl[lo + step]) < t) begin
                    lo += step + 1;
                    cnt -= step + 1;
                end else begin
                    cnt = step;
                end
            end
            k = (lo > n - 1) ? n - 1 : lo;
            if (k < 1) k = 1;
            pp = breakpoint_tbl[k-1];
            pn = breakpoint_tbl[k];
            diff = pn - pp;
            num = t - pp;
            if (diff <= 0 || num <= 0) lambda = 0;
            else if (num >= diff) lambda = 64'sd65536;
            else lambda = (num <<< 16) / diff;
            for (int e = 0; e < m; e++) begin
                vp = sample_tbl[(k-1)*8 + e];
                vn = sample_tbl[k*8 + e];
                prod = (vn - vp) * lambda;
                r.value = 32'(vp + (prod >>> 16));   // arithmetic shift floors
                r.element = 3'(e);
                r.status = ST_OK;
                r.last = (e == m - 1);
                queue_expected(r);
            end
        endfunction

        // called for every accepted request
        function void note_request(logic [1:0] f, logic [7:0] pi, logic [2:0] ei,
                                   logic signed [31:0] wd, logic signed [31:0] qp);
            case (f)
                FUNC_WR_POINT: breakpoint_tbl[pi] = wd;
                FUNC_WR_VALUE: sample_tbl[pi*8 + ei] = wd;
                FUNC_QUERY:    predict_query(qp);
                default: ;
            endcase
        endfunction

        function void check_result(interp_result_t got);
            interp_result_t exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d element=%0d status=%0d last=%0d",
                         $realtime, got.value, got.element, got.status, got.last);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.value !== exp_r.value) begin
                $display("%0t: value expected %0d got %0d", $realtime, exp_r.value, got.value);
                mismatches++;
            end
            if (got.element !== exp_r.element) begin
                $display("%0t: element expected %0d got %0d", $realtime, exp_r.element,
                         got.element);
                mismatches++;
            end
            if (got.status !== exp_r.status) begin
                $display("%0t: status expected %0d got %0d", $realtime, exp_r.status,
                         got.status);
                mismatches++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last expected %0d got %0d", $realtime, exp_r.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_func = FUNC_WR_POINT;
    logic [7:0]         i_point_index = '0;
    logic [2:0]         i_element_index = '0;
    logic signed [31:0] i_write_data = '0;
    logic signed [31:0] i_query_point = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_value;
    logic [2:0]         o_out_element;
    logic [1:0]         o_status;
    logic               o_last;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = REG_POINT_COUNT;
    logic [15:0]        i_cfg_data = '0;

    interp_scoreboard sb = new();
    bit send_no_gaps = 0;      // stretches where the sender never idles
    bit recv_no_stalls = 0;    // same for the receiver
    bit hold_off_req = 0;      // asks the receiver for one long hold-off

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    vector_table_linear_interpolator uut (.*);

    always #6 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one request; valid stays high after acceptance unless a gap follows.
    task automatic send_req(logic [1:0] f, int pi, int ei, int wd, int qp);
        int gap;
        gap = send_no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_point_index <= pi[7:0];
        i_element_index <= ei[2:0];
        i_write_data <= wd;
        i_query_point <= qp;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(f, pi[7:0], ei[2:0], wd, qp);
    endtask

    // Drop valid, let all results drain, then give trailing work time to finish.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(addr, data);
    endtask

    task automatic configure(int pc, int ec, int tol);
        drain();
        write_reg(REG_POINT_COUNT, pc[15:0]);
        write_reg(REG_ELEMENT_COUNT, ec[15:0]);
        write_reg(REG_TOLERANCE, tol[15:0]);
    endtask

    // Ascending breakpoints with a random spacing scale, then every used value.
    task automatic fill_table();
        int     n, m;
        longint spacing, pos;
        n = sb.points_used();
        m = sb.elements_used();
        spacing = longint'(1) << $urandom_range(0, 22);
        pos = -(spacing * n) / 2 + $signed($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < n; i++) begin
            send_req(FUNC_WR_POINT, i, $urandom, pos[31:0], $urandom);
            pos += 1 + (longint'($urandom) % spacing);
        end
        for (int i = 0; i < n; i++)
            for (int e = 0; e < m; e++)
                send_req(FUNC_WR_VALUE, i, e,
                         ($urandom_range(0, 2) == 0) ? $signed($urandom_range(0, 2000)) - 1000
                                                     : $urandom, $urandom);
    endtask

    // Query positions aimed at breakpoints, brackets and the tolerance edges.
    function automatic logic signed [31:0] pick_query_point();
        int     n, i;
        longint p_head, p_tail, a, b, t, tl;
        n = sb.points_used();
        tl = sb.tolerance_reg;
        p_head = sb.breakpoint_tbl[0];
        p_tail = sb.breakpoint_tbl[n-1];
        i = $urandom_range(0, n - 1);
        a = sb.breakpoint_tbl[i];
        b = (i < n - 1) ? longint'(sb.breakpoint_tbl[i+1]) : a;
        case ($urandom_range(0, 7))
            0: t = a;
            1, 2: t = (b > a) ? a + longint'($urandom) % (b - a) : a;
            3: t = p_tail + $urandom_range(0, tl);
            4: t = p_tail + tl + 1 + $urandom_range(0, 1000);
            5: t = p_head - $urandom_range(0, tl);
            6: t = p_head - tl - 1 - $urandom_range(0, 1000);
            default: t = $signed($urandom);
        endcase
        if (t > Q_MAX) t = Q_MAX;
        if (t < Q_MIN) t = Q_MIN;
        return t[31:0];
    endfunction

    // Mostly queries, with stray writes (which can unsort the table) and dead requests.
    task automatic random_traffic(int count);
        int n, sel;
        n = sb.points_used();
        for (int j = 0; j < count; j++) begin
            if (j % 20 == 0) send_no_gaps = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 7)
                send_req(FUNC_QUERY, $urandom, $urandom, $urandom, pick_query_point());
            else if (sel == 7)
                send_req(FUNC_WR_POINT, $urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                             : $urandom,
                         $urandom, $urandom, $urandom);
            else if (sel == 8)
                send_req(FUNC_WR_VALUE, $urandom, $urandom, $urandom, $urandom);
            else
                send_req(2'd3, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: random stalls, stall-free stretches, one long hold-off on request.
    initial begin
        int stall, taken;
        interp_result_t got;
        taken = 0;
        wait (i_rst_n);
        forever begin
            if (taken % 40 == 0) recv_no_stalls = ($urandom_range(0, 3) == 0);
            if (hold_off_req) begin
                hold_off_req = 0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                stall = recv_no_stalls ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!o_valid);
            got.value = o_value;
            got.element = o_out_element;
            got.status = o_status;
            got.last = o_last;
            sb.check_result(got);
            taken++;
        end
    end

    // Main sequence: directed phases first, then randomized phases.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: single point, single element, tolerance one.
        send_req(FUNC_WR_POINT, 0, 0, 32'sd1000, 0);
        send_req(FUNC_WR_VALUE, 0, 0, 32'sd777, 0);
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd1000);
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd1001);
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd1002);   // just past the tolerance: above
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd999);
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd998);    // just below the tolerance: below
        send_req(2'd3, 8'hFF, 3'h7, Q_MIN, Q_MAX);  // unused code, no result

        // Full-range span with extreme values, zero tolerance, all eight elements.
        configure(2, 8, 0);
        send_req(FUNC_WR_POINT, 0, 0, Q_MIN, 0);
        send_req(FUNC_WR_POINT, 1, 0, Q_MAX, 0);
        for (int e = 0; e < 8; e++) begin
            send_req(FUNC_WR_VALUE, 0, e, e[0] ? Q_MAX : Q_MIN, 0);
            send_req(FUNC_WR_VALUE, 1, e, e[0] ? Q_MIN : Q_MAX, 0);
        end
        send_req(FUNC_QUERY, 0, 0, 0, Q_MIN);
        send_req(FUNC_QUERY, 0, 0, 0, Q_MAX);
        send_req(FUNC_QUERY, 0, 0, 0, 32'sd0);
        send_req(FUNC_QUERY, 0, 0, 0, Q_MIN + 1);
        send_req(FUNC_QUERY, 0, 0, 0, Q_MAX - 1);

        // Out-of-range registers: zero counts act as one, largest tolerance.
        configure(0, 0, 16'hFFFF);
        fill_table();
        random_traffic(10);

        // Element count above the maximum clamps to eight.
        configure(3, 15, $urandom);
        fill_table();
        random_traffic(20);

        // Larger table; the receiver holds off once so the block backs up.
        configure(32, 1, 100);
        fill_table();
        hold_off_req = 1;
        random_traffic(40);

        for (int ph = 0; ph < 2; ph++) begin
            configure($urandom_range(2, 6), $urandom_range(1, 4), $urandom_range(0, 4000));
            fill_table();
            random_traffic(15);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
